### src/bphd_pkg.sv
// shared types, constants and codes of the button press, hold and double press classifier
package bphd_pkg;

   // default width of the tick counters
   localparam int COUNT_WIDTH_DEF = 16;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int TICKS_W     = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_LEVEL  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOUBLE_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TICKS    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_TICKS  = 2'd3;

   // register values after reset
   localparam logic               ACTIVE_LEVEL_RST  = 1'b0;
   localparam logic               DOUBLE_ENABLE_RST = 1'b0;
   localparam logic [TICKS_W-1:0] HOLD_TICKS_RST    = 16'd100;
   localparam logic [TICKS_W-1:0] WINDOW_TICKS_RST  = 16'd30;

   // stream widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;
   localparam int STATUS_W   = 3;
   localparam int TALLY_W    = 2;

   // item kinds
   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_READ = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OPEN     = 3'd0,
      ST_PRESSED  = 3'd1,
      ST_HELD     = 3'd2,
      ST_RELEASED = 3'd3,
      ST_DOUBLE   = 3'd4
   } status_type;

   // one item held in the input register
   typedef struct packed {
      logic valid;
      logic action;
      logic level;
   } item_type;

   // classifier state seen from outside the core
   typedef struct packed {
      logic               window_active;
      logic [TALLY_W-1:0] press_tally;
   } monitor_type;

endpackage

### src/bphd_in_stage.sv
// input register of the request stream
module bphd_in_stage
   import bphd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  advance,
   output item_type              item
);

   logic valid_ff, valid_in;
   logic action_ff, action_in;
   logic level_ff, level_in;
   logic load;

   // the register takes a new transfer when empty or when its item moves on
   assign req_tready = !valid_ff || advance;
   assign load       = req_tready;

   always_comb begin
      valid_in  = valid_ff;
      action_in = action_ff;
      level_in  = level_ff;
      if (load) begin
         valid_in  = req_tvalid;
         action_in = req_tdata[0];
         level_in  = req_tdata[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      level_ff  <= level_in;
   end

   assign item = '{valid: valid_ff, action: action_ff, level: level_ff};

endmodule

### src/bphd_core.sv
// configuration registers and the press, hold and window state update
module bphd_core
   import bphd_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  item_type               item,
   input  logic                   out_free,
   output logic                   advance,
   output logic                   res_valid,
   output status_type             res_status,
   output monitor_type            monitor
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [TALLY_W-1:0]     TALLY_MAX = {TALLY_W{1'b1}};
   localparam logic [TALLY_W-1:0]     TALLY_ONE = TALLY_W'(1);

   logic               active_level_ff, active_level_in;
   logic               double_enable_ff, double_enable_in;
   logic [TICKS_W-1:0] hold_ticks_ff, hold_ticks_in;
   logic [TICKS_W-1:0] window_ticks_ff, window_ticks_in;

   logic [COUNT_WIDTH-1:0] pressed_count_ff, pressed_count_in;
   status_type             status_ff, status_in;
   logic                   window_active_ff, window_active_in;
   logic [COUNT_WIDTH-1:0] window_count_ff, window_count_in;
   logic [TALLY_W-1:0]     press_tally_ff, press_tally_in;

   logic [COUNT_WIDTH-1:0] pressed_inc;
   logic                   over_hold;
   logic                   window_due;

   // configuration writes
   always_comb begin
      active_level_in  = active_level_ff;
      double_enable_in = double_enable_ff;
      hold_ticks_in    = hold_ticks_ff;
      window_ticks_in  = window_ticks_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ACTIVE_LEVEL:  active_level_in  = csr_wdata[0];
            CSR_DOUBLE_ENABLE: double_enable_in = csr_wdata[0];
            CSR_HOLD_TICKS:    hold_ticks_in    = csr_wdata[TICKS_W-1:0];
            CSR_WINDOW_TICKS:  window_ticks_in  = csr_wdata[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff  <= ACTIVE_LEVEL_RST;
         double_enable_ff <= DOUBLE_ENABLE_RST;
         hold_ticks_ff    <= HOLD_TICKS_RST;
         window_ticks_ff  <= WINDOW_TICKS_RST;
      end else begin
         active_level_ff  <= active_level_in;
         double_enable_ff <= double_enable_in;
         hold_ticks_ff    <= hold_ticks_in;
         window_ticks_ff  <= window_ticks_in;
      end
   end

   // a read waits for room in the result register, a tick never waits
   assign advance   = item.valid && (item.action == ACT_TICK || out_free);
   assign res_valid = advance && item.action == ACT_READ;
   assign res_status = status_ff;

   assign pressed_inc = (pressed_count_ff != COUNT_MAX) ? pressed_count_ff + 1'b1
                                                        : pressed_count_ff;
   assign over_hold = {{TICKS_W{1'b0}}, pressed_inc} >
                      {{COUNT_WIDTH{1'b0}}, hold_ticks_ff};

   // state update for one tick or read
   always_comb begin
      pressed_count_in = pressed_count_ff;
      status_in        = status_ff;
      window_active_in = window_active_ff;
      window_count_in  = window_count_ff;
      press_tally_in   = press_tally_ff;
      window_due       = 1'b0;
      if (advance) begin
         if (item.action == ACT_READ) begin
            if (status_ff != ST_HELD) begin
               status_in = ST_OPEN;
            end
         end else begin
            // window runs at the start of the tick
            if (window_active_ff && window_count_ff != COUNT_MAX) begin
               window_count_in = window_count_ff + 1'b1;
            end
            if (item.level == active_level_ff) begin
               pressed_count_in = pressed_inc;
               if (over_hold) begin
                  status_in        = ST_HELD;
                  window_active_in = 1'b0;
                  window_count_in  = '0;
                  press_tally_in   = '0;
               end
            end else begin
               if (pressed_count_ff != '0) begin
                  if (status_ff == ST_HELD) begin
                     status_in = ST_RELEASED;
                  end else if (!double_enable_ff) begin
                     status_in = ST_PRESSED;
                  end else begin
                     window_active_in = 1'b1;
                     if (press_tally_ff != TALLY_MAX) begin
                        press_tally_in = press_tally_ff + 1'b1;
                     end
                  end
               end
               pressed_count_in = '0;
            end
            // window decision at the end of the tick
            window_due = double_enable_ff && window_active_in &&
                         ({{TICKS_W{1'b0}}, window_count_in} >=
                          {{COUNT_WIDTH{1'b0}}, window_ticks_ff});
            if (window_due) begin
               status_in        = (press_tally_in == TALLY_ONE) ? ST_PRESSED : ST_DOUBLE;
               window_active_in = 1'b0;
               window_count_in  = '0;
               press_tally_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_count_ff <= '0;
         status_ff        <= ST_OPEN;
         window_active_ff <= 1'b0;
         window_count_ff  <= '0;
         press_tally_ff   <= '0;
      end else begin
         pressed_count_ff <= pressed_count_in;
         status_ff        <= status_in;
         window_active_ff <= window_active_in;
         window_count_ff  <= window_count_in;
         press_tally_ff   <= press_tally_in;
      end
   end

   assign monitor = '{window_active: window_active_ff, press_tally: press_tally_ff};

endmodule

### src/bphd_out_stage.sv
// result register of the response stream
module bphd_out_stage
   import bphd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  res_valid,
   input  status_type            res_status,
   output logic                  out_free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic                valid_ff, valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   // room when empty or when the held result is taken this cycle
   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in  = valid_ff;
      status_in = status_ff;
      if (res_valid) begin
         valid_in  = 1'b1;
         status_in = res_status;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-STATUS_W){1'b0}}, status_ff};

endmodule

### src/button_press_hold_double_classifier.sv
// Button classifier: takes one tick or read transfer every clock unless a read is held in the
// input register. A transfer first lands in the input register; when it moves on, the counters
// and status are updated in one pass, and a read places its status in the result register,
// from which the result is offered. Ticks never wait on the response side; a read waits only
// while the result register is full and not being taken. Tick counts for hold and the double
// press window are to be written through the csr port only while the block is idle; the block
// itself does not enforce this.
module button_press_hold_double_classifier
   import bphd_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [0] action, [1] button_level
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [2:0] status
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   item_type    item;
   logic        advance;
   logic        out_free;
   logic        res_valid;
   status_type  res_status;
   monitor_type monitor;

   bphd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .item       (item)
   );

   bphd_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item       (item),
      .out_free   (out_free),
      .advance    (advance),
      .res_valid  (res_valid),
      .res_status (res_status),
      .monitor    (monitor)
   );

   bphd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res_status (res_status),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // a closed window carries no tally
   assert property (@(posedge clock) disable iff (reset)
      !monitor.window_active |-> monitor.press_tally == '0)
      else $error("press tally left over with no open window");

   // a new result only follows a read leaving the input register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(res_valid))
      else $error("result offered without a read");

   // the request side stalls only behind an occupied input register
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> item.valid && item.action == ACT_READ && !out_free)
      else $error("request stalled with no blocked read");

endmodule
